@@ hdl/assert_macros.svh @@
// Assertion macros shared by the adaptive delta modulation encoder RTL.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever cond holds, conseq holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Whenever cond holds, conseq holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

@@ hdl/adm_enc_pkg.sv @@
// Shared types and constants for the adaptive delta modulation encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package adm_enc_pkg;

  localparam int unsigned GAIN_FRAC_BITS = 5;
  localparam logic [7:0]  TOP_BIT        = 8'h80;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_MIN    = 2'd0;
  localparam logic [1:0] REG_STEP_MAX    = 2'd1;
  localparam logic [1:0] REG_GAIN_SAME   = 2'd2;
  localparam logic [1:0] REG_GAIN_CHANGE = 2'd3;

  localparam logic [7:0] RST_STEP_MIN    = 8'd2;
  localparam logic [7:0] RST_STEP_MAX    = 8'd64;
  localparam logic [7:0] RST_GAIN_SAME   = 8'd48;
  localparam logic [7:0] RST_GAIN_CHANGE = 8'd16;

  typedef enum logic [1:0] {
    KIND_RAW   = 2'd0,
    KIND_CODE  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] step_min;
    logic [7:0] step_max;
    logic [7:0] gain_same;
    logic [7:0] gain_change;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } res_t;

  // Up to two results produced by one item, slot 0 first
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      r;
  } push_t;

endpackage

`default_nettype wire

@@ hdl/adaptive_delta_modulation_encoder_top.sv @@
// Channel     Dir  Payload
// s_axis      in   tdata[7:0] sample, tuser[0] restart, tlast end_block
// m_axis      out  tdata[7:0] out_byte, tuser[1:0] out_kind, tlast last_of_run
// cfg         in   cfg_index[1:0] register, cfg_data[7:0] value
//
// One item per cycle while the queue has room: an accepted item is registered,
// then coded. An item yields zero, one or two results into a four-entry result
// queue; the coder stalls while more than two results are queued, so the
// output rate of one result per cycle is the limit. A result passes the input
// register and the queue before it is on the output, and a stall can delay it.
// Synchronous reset clears coder and queue state and loads register defaults.
// Depends on adm_enc_pkg, adm_enc_cfg, adm_enc_core, adm_enc_outq.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_delta_modulation_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] sample
  input  wire logic [0:0] s_tuser,   // [0] restart
  input  wire logic       s_tlast,   // end_block
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [1:0]      m_tuser,   // [1:0] out_kind
  output logic            m_tlast,   // last_of_run
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import adm_enc_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  q_space;

  adm_enc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adm_enc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cfg      (cfg),
    .q_space  (q_space),
    .push     (push)
  );

  adm_enc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .q_space  (q_space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ hdl/adm_enc_cfg.sv @@
// Configuration register file: step bounds and Q3.5 gains.
// Depends on adm_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adm_enc_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output adm_enc_pkg::cfg_t      cfg
);
  import adm_enc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_min    <= RST_STEP_MIN;
      cfg.step_max    <= RST_STEP_MAX;
      cfg.gain_same   <= RST_GAIN_SAME;
      cfg.gain_change <= RST_GAIN_CHANGE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEP_MIN:    cfg.step_min    <= cfg_data;
        REG_STEP_MAX:    cfg.step_max    <= cfg_data;
        REG_GAIN_SAME:   cfg.gain_same   <= cfg_data;
        REG_GAIN_CHANGE: cfg.gain_change <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/adm_enc_core.sv @@
// Input register and single-pass coder: compare, level update, bit packing,
// step adaptation. Emits up to two results per item. Depends on adm_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adm_enc_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] sample
  input  wire logic [0:0]        s_tuser,   // [0] restart
  input  wire logic              s_tlast,   // end_block
  input  wire adm_enc_pkg::cfg_t cfg,
  input  wire logic              q_space,
  output adm_enc_pkg::push_t     push
);
  import adm_enc_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic       in_valid;
  logic [7:0] in_sample;
  logic       in_restart;
  logic       in_end;

  // coder state
  logic [7:0] level, level_next;
  logic [7:0] step_size, step_size_next;
  logic       prev_bit, prev_bit_next;
  logic [2:0] pos, pos_next;
  logic [7:0] pack, pack_next;
  logic       first_pending, first_pending_next;

  logic        fire;
  logic [7:0]  step_eff;
  logic        coded_bit;
  logic [7:0]  lev_dn;
  logic [8:0]  lev_sum;
  logic [7:0]  lev_up;
  logic [7:0]  gain;
  logic [15:0] prod;
  logic [10:0] scaled;
  logic [10:0] lo_clamped;
  logic [7:0]  pack_set;
  logic [1:0]  n;

  assign fire     = in_valid && q_space;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample  <= s_tdata;
      in_restart <= s_tuser[0];
      in_end     <= s_tlast;
    end
  end

  always_comb begin
    step_eff  = first_pending ? cfg.step_min : step_size;
    coded_bit = in_sample > level;
    lev_dn    = (level > step_eff) ? (level - step_eff) : 8'd0;
    lev_sum   = {1'b0, level} + {1'b0, step_eff};
    lev_up    = lev_sum[8] ? 8'hFF : lev_sum[7:0];
    gain      = (coded_bit == prev_bit) ? cfg.gain_same : cfg.gain_change;
    prod      = {8'd0, gain} * {8'd0, step_eff};
    scaled    = prod[15:GAIN_FRAC_BITS];
    lo_clamped = (scaled < {3'd0, cfg.step_min}) ? {3'd0, cfg.step_min} : scaled;
    pack_set  = coded_bit ? (pack | (TOP_BIT >> pos)) : pack;

    level_next         = level;
    step_size_next     = step_size;
    prev_bit_next      = prev_bit;
    pos_next           = pos;
    pack_next          = pack;
    first_pending_next = first_pending;
    push               = '0;
    n                  = 2'd0;

    if (in_restart) begin
      push.r[0].data     = in_sample;
      push.r[0].kind     = KIND_RAW;
      n                  = 2'd1;
      level_next         = in_sample;
      first_pending_next = 1'b1;
      pos_next           = 3'd0;
      pack_next          = 8'd0;
    end else begin
      level_next         = coded_bit ? lev_up : lev_dn;
      first_pending_next = 1'b0;
      prev_bit_next      = coded_bit;
      step_size_next     = (lo_clamped > {3'd0, cfg.step_max}) ? cfg.step_max
                                                               : lo_clamped[7:0];
      if (pos == 3'd7) begin
        push.r[0].data = pack_set;
        push.r[0].kind = KIND_CODE;
        n              = 2'd1;
        pack_next      = 8'd0;
        pos_next       = 3'd0;
      end else begin
        pack_next = pack_set;
        pos_next  = pos + 3'd1;
      end
    end

    if (in_end) begin
      if (pos_next != 3'd0) begin
        push.r[n[0]].data = pack_next;
        push.r[n[0]].kind = KIND_CODE;
        n                 = n + 2'd1;
      end
      push.r[n[0]].data = {5'd0, pos_next};
      push.r[n[0]].kind = KIND_COUNT;
      n                 = n + 2'd1;
      pos_next          = 3'd0;
      pack_next         = 8'd0;
    end

    if (n == 2'd2) begin
      push.r[1].last = 1'b1;
    end else if (n == 2'd1) begin
      push.r[0].last = 1'b1;
    end
    push.n = fire ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= 8'd0;
      step_size     <= 8'd0;
      prev_bit      <= 1'b0;
      pos           <= 3'd0;
      pack          <= 8'd0;
      first_pending <= 1'b1;
    end else if (fire) begin
      level         <= level_next;
      step_size     <= step_size_next;
      prev_bit      <= prev_bit_next;
      pos           <= pos_next;
      pack          <= pack_next;
      first_pending <= first_pending_next;
    end
  end

  `ASSERT_IMPL(a_push_needs_fire, clk, rst, push.n != 2'd0, fire, "push without item")
  `ASSERT_NEXT(a_restart_seeds, clk, rst, fire && in_restart, first_pending && pos == 3'd0, "bad seed")

endmodule

`default_nettype wire

@@ hdl/adm_enc_outq.sv @@
// Result queue: four entries, takes up to two results per cycle, sends one
// while the receiver is ready. Depends on adm_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adm_enc_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adm_enc_pkg::push_t push,
  output logic                    q_space,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [7:0]              m_tdata,   // [7:0] out_byte
  output logic [1:0]              m_tuser,   // [1:0] out_kind
  output logic                    m_tlast    // last_of_run
);
  import adm_enc_pkg::*;
  `include "assert_macros.svh"

  res_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QPTR_W:0]   count, count_next;
  logic              pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = count != '0;
  assign q_space  = count <= (QPTR_W + 1)'(QUEUE_DEPTH - 2);
  assign m_tdata  = entries[head].data;
  assign m_tuser  = entries[head].kind;
  assign m_tlast  = entries[head].last;

  always_comb begin
    count_next = count + {{(QPTR_W - 1){1'b0}}, push.n} - {{QPTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      tail  <= tail + QPTR_W'(push.n);
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[tail] <= push.r[0];
    end
    if (push.n == 2'd2) begin
      entries[tail + QPTR_W'(1)] <= push.r[1];
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue overflow")
  `ASSERT_IMPL(a_push_room, clk, rst, push.n != 2'd0, q_space, "push into a full queue")

endmodule

`default_nettype wire

@@ sim/adaptive_delta_modulation_encoder_top_tb.sv @@
// Self-checking testbench for adaptive_delta_modulation_encoder_top.
// Directed table, then random blocks under several register settings, checked against
// an in-bench coder model. Depends on adm_enc_pkg and the encoder RTL.
`timescale 1ns / 1ps

module adaptive_delta_modulation_encoder_top_tb;
  import adm_enc_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // margin for a result still in flight
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 130;
  localparam res_t NO_RES      = '0;

  typedef struct packed {
    logic [7:0] smp;
    logic       rs;
    logic       eb;
    logic [1:0] nt;   // results typed in by hand; 0 = use the coder model
    res_t       t0;
    res_t       t1;
  } stim_row_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = '0;
  logic [0:0] s_tuser   = '0;
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_STEP_MIN;
  logic [7:0] cfg_data  = '0;

  adaptive_delta_modulation_encoder_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Coder model state
  cfg_t       regs_model = '{RST_STEP_MIN, RST_STEP_MAX, RST_GAIN_SAME, RST_GAIN_CHANGE};
  logic [7:0] trk_level  = '0;
  logic [7:0] step_now   = '0;
  logic       last_bit   = 1'b0;
  int         bits_held  = 0;
  logic [7:0] pack_byte  = '0;
  logic       seed_step_pending = 1'b1;

  res_t expected_codes [$];
  res_t head_code;
  int   mismatches     = 0;
  int   items_sent     = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  bit   hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      REG_STEP_MIN:    regs_model.step_min    = val;
      REG_STEP_MAX:    regs_model.step_max    = val;
      REG_GAIN_SAME:   regs_model.gain_same   = val;
      REG_GAIN_CHANGE: regs_model.gain_change = val;
      default: ;
    endcase
  endfunction

  // Advances the coder model by one item; queues its results when push_en is set.
  function automatic void encode_sample(input logic [7:0] smp, input logic rs,
                                        input logic eb, input bit push_en);
    res_t outs [2];
    int   n;
    logic code_bit;
    int   lvl;
    int   scaled;
    n = 0;
    if (rs) begin
      outs[n] = '{data: smp, kind: KIND_RAW, last: 1'b0};
      n++;
      trk_level = smp;
      seed_step_pending = 1'b1;
      bits_held = 0;
      pack_byte = '0;
    end else begin
      if (seed_step_pending) begin
        step_now = regs_model.step_min;
        seed_step_pending = 1'b0;
      end
      if (smp <= trk_level) begin
        code_bit = 1'b0;
        lvl = int'(trk_level) - int'(step_now);
        if (lvl < 0) lvl = 0;
      end else begin
        code_bit = 1'b1;
        lvl = int'(trk_level) + int'(step_now);
        if (lvl > 255) lvl = 255;
        pack_byte[7 - bits_held] = 1'b1;   // MSB first
      end
      trk_level = lvl[7:0];
      bits_held++;
      if (bits_held == 8) begin
        outs[n] = '{data: pack_byte, kind: KIND_CODE, last: 1'b0};
        n++;
        pack_byte = '0;
        bits_held = 0;
      end
      scaled = (int'((code_bit == last_bit) ? regs_model.gain_same : regs_model.gain_change)
                * int'(step_now)) >> GAIN_FRAC_BITS;
      // lower bound first, so the upper bound wins when they cross
      if (scaled < regs_model.step_min) scaled = regs_model.step_min;
      if (scaled > regs_model.step_max) scaled = regs_model.step_max;
      step_now = scaled[7:0];
      last_bit = code_bit;
    end
    if (eb) begin
      if (bits_held != 0) begin
        outs[n] = '{data: pack_byte, kind: KIND_CODE, last: 1'b0};
        n++;
      end
      outs[n] = '{data: bits_held[7:0], kind: KIND_COUNT, last: 1'b0};
      n++;
      bits_held = 0;
      pack_byte = '0;
    end
    if (n > 0) outs[n-1].last = 1'b1;
    if (push_en)
      for (int i = 0; i < n; i++) expected_codes.push_back(outs[i]);
  endfunction

  function automatic stim_row_t coded_row(input logic [7:0] smp, input logic rs,
                                          input logic eb);
    stim_row_t r;
    r = '0;
    r.smp = smp;
    r.rs = rs;
    r.eb = eb;
    return r;
  endfunction

  task automatic send_item(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.smp;
    s_tuser  <= row.rs;
    s_tlast  <= row.eb;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_sample(row.smp, row.rs, row.eb, row.nt == 0);
    if (row.nt != 0) begin
      expected_codes.push_back(row.t0);
      if (row.nt > 1) expected_codes.push_back(row.t1);
    end
    items_sent++;
  endtask

  // Mostly a seed followed by a coded run closed by end-of-block; some stray flags.
  task automatic send_block();
    int         len;
    int         shape;
    logic [7:0] s;
    len = $urandom_range(1, 24);
    shape = $urandom_range(0, 3);
    s = 8'($urandom);
    if ($urandom_range(9) != 0)
      send_item(coded_row(8'($urandom), 1'b1, $urandom_range(19) == 0));
    for (int k = 0; k < len; k++) begin
      case (shape)
        0:       s = 8'($urandom);
        1:       s = s + 8'($urandom_range(0, 16)) - 8'd8;
        2:       s = $urandom_range(1) ? 8'hFF : 8'h00;
        default: s = s + 8'd5;
      endcase
      send_item(coded_row(s, $urandom_range(29) == 0,
                          (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0)));
    end
  endtask

  task automatic write_regs(input logic [7:0] smin, input logic [7:0] smax,
                            input logic [7:0] gsame, input logic [7:0] gchg);
    logic [1:0] ids  [4];
    logic [7:0] vals [4];
    ids  = '{REG_STEP_MIN, REG_STEP_MAX, REG_GAIN_SAME, REG_GAIN_CHANGE};
    vals = '{smin, smax, gsame, gchg};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(ids[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_codes.size() != 0) @(posedge clk);
    // an item without a result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected result: out_byte %0d out_kind %0d last_of_run %0d",
               m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        head_code = expected_codes.pop_front();
        if (m_tdata !== head_code.data) begin
          $error("out_byte: expected %0d, got %0d", head_code.data, m_tdata);
          mismatches++;
        end
        if (m_tuser !== head_code.kind) begin
          $error("out_kind: expected %0d, got %0d", head_code.kind, m_tuser);
          mismatches++;
        end
        if (m_tlast !== head_code.last) begin
          $error("last_of_run: expected %0d, got %0d", head_code.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t  directed_rows [25];
    int         target;
    int         mid;
    bit         mid_done;
    logic [7:0] smin, smax, gsame, gchg;

    directed_rows = '{
      // coded before any seed: level 0, min step, partial flush of one bit
      '{8'h80, 1'b0, 1'b1, 2'd2, '{8'h80, KIND_CODE, 1'b0}, '{8'h01, KIND_COUNT, 1'b1}},
      '{8'h00, 1'b1, 1'b0, 2'd1, '{8'h00, KIND_RAW, 1'b1}, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // level held at floor
      // seed with end-of-block: raw, then count 0
      '{8'hFF, 1'b1, 1'b1, 2'd2, '{8'hFF, KIND_RAW, 1'b0}, '{8'h00, KIND_COUNT, 1'b1}},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // equal to level codes 0
      '{8'hFE, 1'b1, 1'b0, 2'd1, '{8'hFE, KIND_RAW, 1'b1}, NO_RES},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // level held at ceiling
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h80, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h7F, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h01, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},   // full byte, then count 0
      '{8'h55, 1'b1, 1'b0, 2'd1, '{8'h55, KIND_RAW, 1'b1}, NO_RES},
      '{8'hAA, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h2A, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hD5, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},   // partial byte of three bits
      '{8'h00, 1'b1, 1'b0, 2'd1, '{8'h00, KIND_RAW, 1'b1}, NO_RES},
      // steady rise grows the step, still below its upper bound
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES}
    };

    send_idle_pct = 32;
    recv_idle_pct = 59;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    s_tvalid <= 1'b0;
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 59;
        recv_idle_pct = 32;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          smin = RST_STEP_MIN; smax = RST_STEP_MAX;
          gsame = RST_GAIN_SAME; gchg = RST_GAIN_CHANGE;
        end
        1: begin smin = 8'd1;   smax = 8'd255; gsame = 8'd255; gchg = 8'd255; end
        2: begin smin = 8'd255; smax = 8'd1;   gsame = 8'd0;   gchg = 8'd0;   end  // crossed bounds
        3: begin smin = 8'd1;   smax = 8'd255; gsame = 8'd0;   gchg = 8'd255; end
        default: begin
          smin  = 8'($urandom_range(1, 16));
          smax  = 8'($urandom_range(8, 255));
          gsame = 8'($urandom_range(0, 255));
          gchg  = 8'($urandom_range(0, 255));
        end
      endcase
      write_regs(smin, smax, gsame, gchg);

      target = items_sent + PHASE_ITEMS;
      mid = items_sent + PHASE_ITEMS / 2;
      mid_done = 1'b0;
      while (items_sent < target) begin
        if (!mid_done && items_sent >= mid) begin
          mid_done = 1'b1;
          if (ph == 4) begin
            // output stalled long enough for the result queue to back up into the input
            hold_req = 1'b1;
            while (hold_req) send_block();
          end else if (ph == 5) begin
            s_tvalid <= 1'b0;
            drain_results();
          end
        end
        send_block();
      end
      s_tvalid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/adm_enc_pkg.sv
hdl/adm_enc_cfg.sv
hdl/adm_enc_core.sv
hdl/adm_enc_outq.sv
hdl/adaptive_delta_modulation_encoder_top.sv
sim/adaptive_delta_modulation_encoder_top_tb.sv
